// ===== hdl/fpi_pkg.sv =====
// shared types, widths and constants of the parabolic farrow interpolator
// no dependencies; used by fpi_lane, fpi_merge, farrow_parabolic_interpolator and the testbench
package fpi_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MU_BITS     = 16;

   // coefficient widths: 2*c1 spans six samples, 2*c2 four
   localparam int A_BITS   = SAMPLE_BITS + 3;
   localparam int B_BITS   = SAMPLE_BITS + 2;
   localparam int MU2_BITS = 2 * MU_BITS;
   localparam int PA_BITS  = MU_BITS + 1 + A_BITS;
   localparam int PB_BITS  = MU2_BITS + 1 + B_BITS;
   localparam int SUM_BITS = MU2_BITS + A_BITS + 2;
   localparam int FRAC_BITS = MU2_BITS + 1;
   localparam int Q_BITS   = SUM_BITS - FRAC_BITS;
   localparam int Y_BITS   = Q_BITS + 1;

   localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << MU2_BITS;

   localparam logic signed [Y_BITS-1:0] SAT_HI =
      {{(Y_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [Y_BITS-1:0] SAT_LO =
      {{(Y_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_i;
      logic signed [SAMPLE_BITS-1:0] sample_q;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] interp_i;
      logic signed [SAMPLE_BITS-1:0] interp_q;
   } rsp_payload_type;

   typedef struct packed {
      logic advance;
      logic accept;
   } lane_ctrl_type;

endpackage

// ===== hdl/fpi_lane.sv =====
// one component lane: sample history, coefficients, products and rounded sum
// depends on fpi_pkg
module fpi_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fpi_pkg::lane_ctrl_type                ctrl,
   input  logic signed [fpi_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [fpi_pkg::MU_BITS-1:0]           mu,
   input  logic [fpi_pkg::MU2_BITS-1:0]          mu_sq,
   output logic signed [fpi_pkg::SUM_BITS-1:0]   sum,
   output logic signed [fpi_pkg::SAMPLE_BITS-1:0] x2
);

   logic signed [fpi_pkg::SAMPLE_BITS-1:0] hist0_ff, hist1_ff, hist2_ff;

   logic signed [fpi_pkg::A_BITS-1:0] x0e, x1e, x2e, x3e;
   logic signed [fpi_pkg::A_BITS-1:0] a_in, a_ff;
   logic signed [fpi_pkg::B_BITS-1:0] b_in, b_ff;
   logic signed [fpi_pkg::SAMPLE_BITS-1:0] x2s1_ff, x2s2_ff, x2s3_ff;
   logic signed [fpi_pkg::PA_BITS-1:0] pa_in, pa_ff;
   logic signed [fpi_pkg::PB_BITS-1:0] pb_in, pb_ff;
   logic signed [fpi_pkg::SUM_BITS-1:0] sum_in, sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist0_ff <= '0;
         hist1_ff <= '0;
         hist2_ff <= '0;
      end else if (ctrl.accept) begin
         hist0_ff <= sample;
         hist1_ff <= hist0_ff;
         hist2_ff <= hist1_ff;
      end
   end

   always_comb begin
      x0e    = fpi_pkg::A_BITS'(sample);
      x1e    = fpi_pkg::A_BITS'(hist0_ff);
      x2e    = fpi_pkg::A_BITS'(hist1_ff);
      x3e    = fpi_pkg::A_BITS'(hist2_ff);
      a_in   = (x1e <<< 1) + x1e - x0e - x2e - x3e;
      b_in   = fpi_pkg::B_BITS'(x0e - x1e - x2e + x3e);
      pa_in  = $signed({1'b0, mu}) * a_ff;
      pb_in  = $signed({1'b0, mu_sq}) * b_ff;
      sum_in = fpi_pkg::SUM_BITS'($signed({pa_ff, {fpi_pkg::MU_BITS{1'b0}}}))
             + fpi_pkg::SUM_BITS'(pb_ff) + fpi_pkg::ROUND_HALF;
   end

   // payload stages move together with the valid pipeline in the top level
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         x2s1_ff <= hist1_ff;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         x2s2_ff <= x2s1_ff;
         sum_ff  <= sum_in;
         x2s3_ff <= x2s2_ff;
      end
   end

   assign sum = sum_ff;
   assign x2  = x2s3_ff;

endmodule

// ===== hdl/fpi_merge.sv =====
// merging stage: final shift, add of the base sample, saturation, output register
// depends on fpi_pkg
module fpi_merge (
   input  logic                                   clock,
   input  logic                                   advance,
   input  logic signed [fpi_pkg::SUM_BITS-1:0]    sum_i,
   input  logic signed [fpi_pkg::SUM_BITS-1:0]    sum_q,
   input  logic signed [fpi_pkg::SAMPLE_BITS-1:0] x2_i,
   input  logic signed [fpi_pkg::SAMPLE_BITS-1:0] x2_q,
   output fpi_pkg::rsp_payload_type               payload
);

   function automatic logic signed [fpi_pkg::SAMPLE_BITS-1:0] finish(
      input logic signed [fpi_pkg::SUM_BITS-1:0]    s,
      input logic signed [fpi_pkg::SAMPLE_BITS-1:0] base
   );
      logic signed [fpi_pkg::Q_BITS-1:0] q;
      logic signed [fpi_pkg::Y_BITS-1:0] y;
      q = $signed(s[fpi_pkg::SUM_BITS-1:fpi_pkg::FRAC_BITS]);
      y = fpi_pkg::Y_BITS'(q) + fpi_pkg::Y_BITS'(base);
      if (y > fpi_pkg::SAT_HI) begin
         y = fpi_pkg::SAT_HI;
      end else if (y < fpi_pkg::SAT_LO) begin
         y = fpi_pkg::SAT_LO;
      end
      return y[fpi_pkg::SAMPLE_BITS-1:0];
   endfunction

   fpi_pkg::rsp_payload_type payload_in, payload_ff;

   always_comb begin
      payload_in.interp_i = finish(sum_i, x2_i);
      payload_in.interp_q = finish(sum_q, x2_q);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         payload_ff <= payload_in;
      end
   end

   assign payload = payload_ff;

endmodule

// ===== hdl/farrow_parabolic_interpolator.sv =====
// piecewise-parabolic farrow interpolator, alpha one half, complex samples
// four register stages: coefficients, products, rounded sum and the output register
// throughput: one complex sample per cycle when not stalled; lanes i and q run side by side,
// two multipliers each; the whole pipeline holds while a finished result waits under rsp_stall
// reset (synchronous, active high) clears the history, frac delay and all valid bits
// depends on fpi_pkg, fpi_lane, fpi_merge
module farrow_parabolic_interpolator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fpi_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fpi_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_write_en,
   input  logic [fpi_pkg::MU_BITS-1:0]         csr_write_data
);

   // frac delay register and its square, both loaded by the same write
   logic [fpi_pkg::MU_BITS-1:0]  mu_ff;
   logic [fpi_pkg::MU2_BITS-1:0] mu_sq_ff;

   // valid bits of the three lane stages and of the output register
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;

   logic                   advance;
   fpi_pkg::lane_ctrl_type ctrl;

   logic signed [fpi_pkg::SUM_BITS-1:0]    sum_i, sum_q;
   logic signed [fpi_pkg::SAMPLE_BITS-1:0] x2_i, x2_q;

   // pipeline moves whenever the output register is empty or its transfer completes
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign ctrl.advance = advance;
   assign ctrl.accept  = req_valid && advance;
   assign req_stall    = !advance;
   assign rsp_valid    = rsp_valid_ff;

   // the square comes straight from the write data, so both are ready together
   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff    <= '0;
         mu_sq_ff <= '0;
      end else if (csr_write_en) begin
         mu_ff    <= csr_write_data;
         mu_sq_ff <= csr_write_data * csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   // in-phase lane
   fpi_lane u_lane_i (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (req_payload.sample_i),
      .mu     (mu_ff),
      .mu_sq  (mu_sq_ff),
      .sum    (sum_i),
      .x2     (x2_i)
   );

   // quadrature lane
   fpi_lane u_lane_q (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (req_payload.sample_q),
      .mu     (mu_ff),
      .mu_sq  (mu_sq_ff),
      .sum    (sum_q),
      .x2     (x2_q)
   );

   // rounding shift, add of the base sample, saturation and the output register for both lanes
   fpi_merge u_merge (
      .clock   (clock),
      .advance (advance),
      .sum_i   (sum_i),
      .sum_q   (sum_q),
      .x2_i    (x2_i),
      .x2_q    (x2_q),
      .payload (rsp_payload)
   );

`ifndef NO_ASSERTIONS
   // input is held back only by a result that waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a waiting result");

   // an item in the first stage moves on when the pipeline advances
   a_stage1_moves: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && advance) |=> v2_ff)
      else $error("stage one item lost");

   // an item in the last lane stage reaches the output when the pipeline advances
   a_stage3_moves: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && advance) |=> rsp_valid)
      else $error("stage three item lost");

   // a completed output transfer with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !v3_ff) |=> !rsp_valid)
      else $error("result repeated");
`endif

endmodule

// ===== tb/farrow_parabolic_interpolator_test.sv =====
// self-checking testbench for the parabolic farrow interpolator: directed corner samples,
// then randomised sample streams over several frac delay settings with random idling.
// depends on fpi_pkg and the farrow_parabolic_interpolator rtl; nothing else
module farrow_parabolic_interpolator_test;

   localparam int CLOCK_PERIOD = 12;
   localparam int DRAIN_CYCLES = 8;       // pipeline is four deep, allow some margin
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 204;

   localparam longint SAMPLE_MAX = (longint'(1) <<< (fpi_pkg::SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   // holds the sample history and frac delay of the block and the queue of expected outputs
   class interp_ledger;
      longint                       hist_i[3];
      longint                       hist_q[3];
      logic [fpi_pkg::MU_BITS-1:0]  frac_delay;
      fpi_pkg::rsp_payload_type     expected_points[$];
      int                           failures;
      int                           checked;

      function new();
         for (int k = 0; k < 3; k++) begin
            hist_i[k] = 0;
            hist_q[k] = 0;
         end
         frac_delay = '0;
         failures   = 0;
         checked    = 0;
      endfunction

      function void set_delay(logic [fpi_pkg::MU_BITS-1:0] mu);
         frac_delay = mu;
      endfunction

      function int outstanding();
         return expected_points.size();
      endfunction

      // y = x2 + mu*(c1 + mu*c2), halving folded into the final shift, round half up, saturate
      function longint parabolic_point(longint x0, longint x1, longint x2, longint x3);
         longint a, b, mu, acc, y;
         a   = 3 * x1 - x0 - x2 - x3;
         b   = x0 - x1 - x2 + x3;
         mu  = longint'(frac_delay);
         acc = ((mu <<< fpi_pkg::MU_BITS) * a) + (mu * mu * b)
             + (longint'(1) <<< (2 * fpi_pkg::MU_BITS));
         y   = x2 + (acc >>> (2 * fpi_pkg::MU_BITS + 1));
         if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
         end else if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
         end
         return y;
      endfunction

      function void note_sample(fpi_pkg::req_payload_type smp);
         fpi_pkg::rsp_payload_type point;
         point.interp_i = fpi_pkg::SAMPLE_BITS'(parabolic_point(smp.sample_i, hist_i[0],
                                                                hist_i[1], hist_i[2]));
         point.interp_q = fpi_pkg::SAMPLE_BITS'(parabolic_point(smp.sample_q, hist_q[0],
                                                                hist_q[1], hist_q[2]));
         expected_points.push_back(point);
         hist_i[2] = hist_i[1];
         hist_i[1] = hist_i[0];
         hist_i[0] = smp.sample_i;
         hist_q[2] = hist_q[1];
         hist_q[1] = hist_q[0];
         hist_q[0] = smp.sample_q;
      endfunction

      function void check_point(fpi_pkg::rsp_payload_type got);
         fpi_pkg::rsp_payload_type want;
         if (expected_points.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected output i %0d q %0d with nothing pending",
                        got.interp_i, got.interp_q);
            return;
         end
         want = expected_points.pop_front();
         checked++;
         if (got.interp_i !== want.interp_i) begin
            failures++;
            if (failures <= 10)
               $display("output %0d (mu %0d): interp_i expected %0d, got %0d",
                        checked, frac_delay, want.interp_i, got.interp_i);
         end
         if (got.interp_q !== want.interp_q) begin
            failures++;
            if (failures <= 10)
               $display("output %0d (mu %0d): interp_q expected %0d, got %0d",
                        checked, frac_delay, want.interp_q, got.interp_q);
         end
      endfunction
   endclass

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   fpi_pkg::req_payload_type      req_payload    = '0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   fpi_pkg::rsp_payload_type      rsp_payload;
   logic                          csr_write_en   = 1'b0;
   logic [fpi_pkg::MU_BITS-1:0]   csr_write_data = '0;

   interp_ledger ledger = new();

   // idling odds in percent, changed per phase by the stimulus process
   int gap_pct   = 0;
   int stall_pct = 0;
   int samples_sent = 0;
   int delays_loaded = 0;

   // last value per lane, so that some random samples follow a smooth waveform
   logic signed [fpi_pkg::SAMPLE_BITS-1:0] last_i = '0;
   logic signed [fpi_pkg::SAMPLE_BITS-1:0] last_q = '0;

   farrow_parabolic_interpolator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // one input transfer; the payload holds until the block takes it, then an optional gap
   task automatic send_sample(input fpi_pkg::req_payload_type smp);
      req_valid   <= 1'b1;
      req_payload <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.note_sample(smp);
      samples_sent++;
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_pair(input longint si, input longint sq);
      fpi_pkg::req_payload_type smp;
      smp.sample_i = fpi_pkg::SAMPLE_BITS'(si);
      smp.sample_q = fpi_pkg::SAMPLE_BITS'(sq);
      send_sample(smp);
   endtask

   // frac delay is only changed with the pipeline empty
   task automatic load_delay(input logic [fpi_pkg::MU_BITS-1:0] mu);
      req_valid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= mu;
      @(posedge clock);
      csr_write_en <= 1'b0;
      ledger.set_delay(mu);
      delays_loaded++;
   endtask

   // mixture of full-scale noise, smooth waveform steps, tiny values and rail values
   function automatic logic signed [fpi_pkg::SAMPLE_BITS-1:0] pick_field(
      input logic signed [fpi_pkg::SAMPLE_BITS-1:0] prev);
      longint v;
      int     mode;
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
         v = longint'($signed(fpi_pkg::SAMPLE_BITS'($urandom)));
      end else if (mode < 7) begin
         v = longint'(prev) + longint'($urandom_range(0, 1200)) - 600;
      end else if (mode == 7) begin
         v = longint'($urandom_range(0, 8)) - 4;
      end else if (mode == 8) begin
         case ($urandom_range(0, 3))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2: v = 0;
            default: v = -1;
         endcase
      end else begin
         v = longint'(prev) + longint'($urandom_range(0, 4)) - 2;
      end
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      return fpi_pkg::SAMPLE_BITS'(v);
   endfunction

   // result side back-pressure: random stall bursts, none when stall_pct is zero
   initial begin : rsp_backpressure
      wait (!reset);
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // every result transfer is compared with the oldest pending expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_point(rsp_payload);
   end

   initial begin : stimulus
      logic [fpi_pkg::MU_BITS-1:0] phase_mu[PHASE_COUNT];
      int                          phase_gap[PHASE_COUNT];
      int                          phase_stall[PHASE_COUNT];
      fpi_pkg::req_payload_type    smp;

      phase_mu    = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
                      fpi_pkg::MU_BITS'($urandom), 16'h7FFF,
                      fpi_pkg::MU_BITS'($urandom), fpi_pkg::MU_BITS'($urandom)};
      phase_gap   = '{10, 30, 0, 5, 20, 50, 10, 0};
      phase_stall = '{5, 20, 10, 0, 30, 8, 15, 0};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset frac delay is zero and history is clear: output is the sample two back
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair(0, 0);
      send_pair(-1, 1);

      // largest mu with rail-to-rail swings keeps both lanes just inside the rails
      load_delay(16'hFFFF);
      for (int k = 0; k < 4; k++) begin
         send_pair(SAMPLE_MAX, SAMPLE_MIN);
         send_pair(SAMPLE_MIN, SAMPLE_MAX);
      end
      send_pair(SAMPLE_MAX, SAMPLE_MAX);

      // mu one half on 0,0,1,1 lands exactly halfway: +0.5 rounds up, -0.5 rounds to zero
      load_delay(16'h8000);
      send_pair(0, 0);
      send_pair(0, 0);
      send_pair(1, -1);
      send_pair(1, -1);
      send_pair(-1, 1);
      send_pair(2, -2);
      send_pair(-3, 3);

      // random streams, one frac delay per phase; the last phase runs with no idling
      for (int p = 0; p < PHASE_COUNT; p++) begin
         load_delay(phase_mu[p]);
         gap_pct   = phase_gap[p];
         stall_pct = phase_stall[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            smp.sample_i = pick_field(last_i);
            smp.sample_q = pick_field(last_q);
            last_i = smp.sample_i;
            last_q = smp.sample_q;
            send_sample(smp);
         end
      end
      req_valid <= 1'b0;

      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d complex samples sent, %0d interpolated outputs checked",
               samples_sent, ledger.checked);
      $display("summary: %0d frac delay settings loaded, %0d mismatches",
               delays_loaded, ledger.failures);
      if (ledger.failures == 0) begin
         $display("farrow_parabolic_interpolator_test passed");
      end else begin
         $display("farrow_parabolic_interpolator_test failed");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin : watchdog
      #(CLOCK_PERIOD * 400000);
      $display("farrow_parabolic_interpolator_test failed");
      $finish;
   end

endmodule
